@@ hdl/ssdbs_pkg.sv @@
// ---------------------------------------------------------------------------
// SSD block selector package
// Item types, widths, item classes and the squared difference helper used
// by the front end, the back end and the top level of the selector.
// ---------------------------------------------------------------------------
package ssdbs_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned SSD_W  = 28;
  // Three squares of 8-bit differences fit in 18 bits.
  localparam int unsigned PIX_W  = 18;

  localparam logic [SSD_W-1:0] SSD_MAX = {SSD_W{1'b1}};

  localparam int unsigned MID_DEPTH_DEFAULT = 4;
  localparam int unsigned OUT_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [CHAN_W-1:0] orig_blue;
    logic [CHAN_W-1:0] orig_green;
    logic [CHAN_W-1:0] orig_red;
    logic [CHAN_W-1:0] ref_blue;
    logic [CHAN_W-1:0] ref_green;
    logic [CHAN_W-1:0] ref_red;
    logic [IDX_W-1:0]  ref_index;
    logic              block_end;
    logic              final_ref;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] best_ref;
    logic [SSD_W-1:0] best_ssd;
  } out_item_t;

  // How the back end treats an item.
  typedef enum logic [1:0] {
    KIND_ACCUM      = 2'd0,
    KIND_BLOCK_END  = 2'd1,
    KIND_SEARCH_END = 2'd2
  } item_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [IDX_W-1:0] idx;
    item_kind_t       kind;
  } mid_item_t;

  function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
  endfunction

endpackage

@@ hdl/ssdbs_fifo.sv @@
// ---------------------------------------------------------------------------
// SSD block selector queue
// Small first-in first-out queue in flip-flops with full and empty flags.
// ---------------------------------------------------------------------------
module ssdbs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/ssdbs_front.sv @@
// ---------------------------------------------------------------------------
// SSD block selector front end
// Squares the three channel differences of a pixel pair and classifies it.
// ---------------------------------------------------------------------------
module ssdbs_front (
  input  ssdbs_pkg::in_item_t  pixel,
  output ssdbs_pkg::mid_item_t item
);
  import ssdbs_pkg::*;

  logic [2*CHAN_W-1:0] sq_b;
  logic [2*CHAN_W-1:0] sq_g;
  logic [2*CHAN_W-1:0] sq_r;

  always_comb begin
    sq_b = sq_diff(pixel.orig_blue,  pixel.ref_blue);
    sq_g = sq_diff(pixel.orig_green, pixel.ref_green);
    sq_r = sq_diff(pixel.orig_red,   pixel.ref_red);

    item.pix = PIX_W'(sq_b) + PIX_W'(sq_g) + PIX_W'(sq_r);
    item.idx = pixel.ref_index;

    // The last-candidate flag only counts on the last pixel of a block.
    if (!pixel.block_end) begin
      item.kind = KIND_ACCUM;
    end else if (pixel.final_ref) begin
      item.kind = KIND_SEARCH_END;
    end else begin
      item.kind = KIND_BLOCK_END;
    end
  end

endmodule

@@ hdl/ssdbs_back.sv @@
// ---------------------------------------------------------------------------
// SSD block selector back end
// Accumulates block sums, keeps the best reference and emits search results.
// ---------------------------------------------------------------------------
module ssdbs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ssdbs_pkg::mid_item_t  item,
  input  logic                  item_empty,
  output logic                  item_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output ssdbs_pkg::out_item_t  res
);
  import ssdbs_pkg::*;

  logic [SSD_W-1:0] running_sum;
  logic [SSD_W-1:0] least_sum;
  logic [IDX_W-1:0] least_index;
  logic             have_least;

  logic [SSD_W:0]   sum_wide;
  logic [SSD_W-1:0] sum_sat;
  logic             take;
  logic [SSD_W-1:0] cand_sum;
  logic [IDX_W-1:0] cand_index;

  // Stalling on a full result queue for every item keeps the control simple.
  assign item_pop = !item_empty && !res_full;

  always_comb begin
    sum_wide   = {1'b0, running_sum} + (SSD_W + 1)'(item.pix);
    sum_sat    = (sum_wide > {1'b0, SSD_MAX}) ? SSD_MAX : sum_wide[SSD_W-1:0];
    take       = !have_least || (sum_sat < least_sum);
    cand_sum   = take ? sum_sat : least_sum;
    cand_index = take ? item.idx : least_index;
    res_push   = item_pop && (item.kind == KIND_SEARCH_END);
    res.best_ref = cand_index;
    res.best_ssd = cand_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      least_sum   <= '0;
      least_index <= '0;
      have_least  <= 1'b0;
    end else if (item_pop) begin
      case (item.kind)
        KIND_ACCUM: begin
          running_sum <= sum_sat;
        end
        KIND_BLOCK_END: begin
          running_sum <= '0;
          least_sum   <= cand_sum;
          least_index <= cand_index;
          have_least  <= 1'b1;
        end
        KIND_SEARCH_END: begin
          running_sum <= '0;
          least_sum   <= '0;
          least_index <= '0;
          have_least  <= 1'b0;
        end
        default: begin
          running_sum <= running_sum;
        end
      endcase
    end
  end

endmodule

@@ hdl/ssd_reference_block_selector_top.sv @@
// ---------------------------------------------------------------------------
// SSD reference block selector
// Picks, among candidate reference blocks, the one with the smallest sum of
// squared RGB differences against the original block.
// ---------------------------------------------------------------------------
//
//   Channel | Handshake         | Item
//   --------+-------------------+-----------------------------------------
//   input   | push / full       | pixel : original and reference RGB pair,
//           |                   |         ref_index, block_end, final_ref
//   result  | empty / pop       | result: best_ref, best_ssd
//
// One pixel pair is taken every clock cycle while full is low. The front end
// squares the channel differences in the same cycle it accepts the item and
// writes the per-pixel sum into a queue of MID_DEPTH entries. The back end
// takes one entry per cycle while the result queue is not full, does one
// saturating add and one compare, and on the end of a search writes the
// result into a queue of OUT_DEPTH entries, whose oldest entry sits on the
// result ports until it is popped. A held result (pop low) stalls only the
// back end; the front keeps accepting until the middle queue fills. The
// synchronous reset empties both queues and clears the running and best
// sums at once.
// ---------------------------------------------------------------------------
module ssd_reference_block_selector_top #(
  parameter int unsigned MID_DEPTH = ssdbs_pkg::MID_DEPTH_DEFAULT,
  parameter int unsigned OUT_DEPTH = ssdbs_pkg::OUT_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  ssdbs_pkg::in_item_t  pixel,
  output logic                 empty,
  input  logic                 pop,
  output ssdbs_pkg::out_item_t result
);
  import ssdbs_pkg::*;

  mid_item_t front_item;
  mid_item_t back_item;
  logic      mid_empty;
  logic      mid_pop;
  out_item_t res_item;
  logic      res_push;
  logic      res_full;

  // Front end: squares and classifies each accepted pixel pair.
  ssdbs_front u_front (
    .pixel (pixel),
    .item  (front_item)
  );

  // Queue between front and back end, so each side can stall on its own.
  ssdbs_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (mid_pop),
    .rdata (back_item),
    .empty (mid_empty)
  );

  // Back end: block sums, best-candidate tracking and result generation.
  ssdbs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (back_item),
    .item_empty (mid_empty),
    .item_pop   (mid_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_item)
  );

  // Result queue: the oldest result sits on the result ports.
  ssdbs_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

@@ hdl/ssdbs_checker.sv @@
// ---------------------------------------------------------------------------
// SSD block selector checker
// Port-level assertions on the selector, bound to its top level.
// ---------------------------------------------------------------------------
module ssdbs_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 push,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input ssdbs_pkg::out_item_t result
);

  // Reset leaves the result queue empty and the middle queue not full.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // The middle queue fills only through accepted pushes.
  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // A waiting result stays until it is taken.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result vanished without a pop");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(result))
    else $error("result changed while held");

endmodule

bind ssd_reference_block_selector_top ssdbs_checker u_ssdbs_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
